// ===== hw/rtl/peak_valley_step_detector_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PEAK_VALLEY_STEP_DETECTOR_DEFINES_SVH
`define PEAK_VALLEY_STEP_DETECTOR_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define PVSD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pvsd assertion failed");

// Next-cycle implication, held off during reset.
`define PVSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pvsd assertion failed");

`endif

// ===== hw/rtl/pvsd_pkg.sv =====
package pvsd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int STEP_W   = 17;
   localparam int POS_W    = 32;
   localparam int CNT_W    = 8;
   localparam int CSR_W    = 16;

   // Register indexes on the configuration port
   typedef enum logic [2:0] {
      CSR_JITTER_LIMIT    = 3'd0,
      CSR_TREND_CONFIRM   = 3'd1,
      CSR_SWING_THRESHOLD = 3'd2,
      CSR_MEAN_THRESHOLD  = 3'd3,
      CSR_GAP_LIMIT       = 3'd4
   } csr_index_type;

   // Last edge seen, so that each turn is counted once
   typedef enum logic [2:0] {
      EDGE_NONE      = 3'd0,
      EDGE_FALL_LOW  = 3'd1,
      EDGE_FALL_TURN = 3'd2,
      EDGE_RISE_HIGH = 3'd3,
      EDGE_RISE_TURN = 3'd4
   } edge_mark_type;

   localparam logic [7:0]  JITTER_LIMIT_RST    = 8'd8;
   localparam logic [7:0]  TREND_CONFIRM_RST   = 8'd5;
   localparam logic [14:0] SWING_THRESHOLD_RST = 15'd150;
   localparam logic [14:0] MEAN_THRESHOLD_RST  = 15'd700;
   localparam logic [15:0] GAP_LIMIT_RST       = 16'd100;

   localparam logic signed [SAMPLE_W-1:0] EXTREME_LOW  = -16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] EXTREME_HIGH = 16'sd32767;

   localparam logic signed [STEP_W-1:0] STEP_STOPPED = -17'sd1;
   localparam logic signed [STEP_W-1:0] STEP_MAX     = 17'sd65535;

   function automatic logic [CNT_W-1:0] sat_inc8(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

// ===== hw/rtl/peak_valley_step_detector.sv =====
// Peak and valley step detector for one accelerometer axis. Each accepted item
// (a signed sample, with restart in tuser) gives exactly one result item: the step
// count after it (-1 while counting is stopped), the trend direction and a flag for
// a gap or jitter stop on that sample. The block takes one item every clock cycle
// while the result output is not stalled; a result passes through the input
// register and then the result register, and the whole per-sample update of the
// tracking state is combinational compare and add logic between them. While
// the result register waits, one further item is held in the input register.
// Write configuration only while no item is in flight.
module peak_valley_step_detector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] sample
   input  logic [0:0]  req_tuser,  // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [16:0] step_value, [23:17] zero
   output logic [1:0]  rsp_tuser,  // [0] trend_up, [1] stopped
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [pvsd_pkg::CSR_W-1:0] csr_wdata
);
   import pvsd_pkg::*;

   // configuration
   logic [7:0]  jitter_limit_ff, trend_confirm_ff;
   logic [14:0] swing_threshold_ff, mean_threshold_ff;
   logic [15:0] gap_limit_ff;

   // input and result stages
   logic                       in_valid_ff;
   logic signed [SAMPLE_W-1:0] in_sample_ff;
   logic                       in_restart_ff;
   logic                       out_valid_ff;
   logic signed [STEP_W-1:0]   out_step_ff;
   logic                       out_trend_ff, out_stop_ff;
   logic                       advance;

   // tracking state
   logic [POS_W-1:0]           position_ff, position_in;
   logic [POS_W-1:0]           anchor_pos_ff, anchor_pos_in;
   logic [POS_W-1:0]           peak_pos_ff, peak_pos_in;
   logic [POS_W-1:0]           valley_pos_ff, valley_pos_in;
   logic signed [SAMPLE_W-1:0] running_max_ff, running_max_in;
   logic signed [SAMPLE_W-1:0] running_min_ff, running_min_in;
   logic signed [SAMPLE_W-1:0] last_peak_ff, last_peak_in;
   logic signed [SAMPLE_W-1:0] last_valley_ff, last_valley_in;
   logic                       rising_ff, rising_in;
   edge_mark_type              edge_mark_ff, edge_mark_in;
   logic [CNT_W-1:0]           against_ff, against_in;
   logic [CNT_W-1:0]           change_ff, change_in;
   logic signed [STEP_W-1:0]   step_ff, step_in;
   logic                       stop_in;

   logic [POS_W-1:0]           gap;
   logic signed [STEP_W-1:0]   swing;

   function automatic logic qualifies(
      input logic signed [STEP_W-1:0]   sw,
      input logic [CNT_W-1:0]           chg,
      input logic signed [SAMPLE_W-1:0] pk,
      input logic signed [SAMPLE_W-1:0] vl,
      input logic [14:0]                swing_thr,
      input logic [14:0]                mean_thr,
      input logic [7:0]                 jit_lim
   );
      logic signed [STEP_W-1:0] sum;
      logic signed [STEP_W-1:0] half;
      logic signed [STEP_W-1:0] mag;
      sum  = STEP_W'(pk) + STEP_W'(vl);
      // round toward zero before halving
      half = (sum + $signed({{(STEP_W-1){1'b0}}, sum[STEP_W-1]})) >>> 1;
      mag  = half[STEP_W-1] ? -half : half;
      return ($signed({2'b00, swing_thr}) < sw) && (jit_lim > chg) &&
             ($signed({2'b00, mean_thr}) < mag);
   endfunction

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_step_ff};
   assign rsp_tuser  = {out_stop_ff, out_trend_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         jitter_limit_ff    <= JITTER_LIMIT_RST;
         trend_confirm_ff   <= TREND_CONFIRM_RST;
         swing_threshold_ff <= SWING_THRESHOLD_RST;
         mean_threshold_ff  <= MEAN_THRESHOLD_RST;
         gap_limit_ff       <= GAP_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_JITTER_LIMIT:    jitter_limit_ff    <= csr_wdata[7:0];
            CSR_TREND_CONFIRM:   trend_confirm_ff   <= csr_wdata[7:0];
            CSR_SWING_THRESHOLD: swing_threshold_ff <= csr_wdata[14:0];
            CSR_MEAN_THRESHOLD:  mean_threshold_ff  <= csr_wdata[14:0];
            CSR_GAP_LIMIT:       gap_limit_ff       <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      position_in    = in_restart_ff ? '0 : position_ff;
      anchor_pos_in  = anchor_pos_ff;
      peak_pos_in    = peak_pos_ff;
      valley_pos_in  = valley_pos_ff;
      running_max_in = running_max_ff;
      running_min_in = running_min_ff;
      last_peak_in   = last_peak_ff;
      last_valley_in = last_valley_ff;
      rising_in      = rising_ff;
      edge_mark_in   = edge_mark_ff;
      against_in     = against_ff;
      change_in      = change_ff;
      step_in        = step_ff;
      stop_in        = 1'b0;
      swing          = '0;

      // restart extreme tracking at position zero
      if (position_in == '0) begin
         running_max_in = EXTREME_LOW;
         running_min_in = EXTREME_HIGH;
         peak_pos_in    = '0;
         valley_pos_in  = '0;
         anchor_pos_in  = '0;
      end
      if (position_in != '1) begin
         position_in = position_in + 1'b1;
      end
      gap = position_in - anchor_pos_in;

      if (gap > POS_W'(gap_limit_ff) || change_ff > jitter_limit_ff) begin
         step_in      = STEP_STOPPED;
         change_in    = '0;
         edge_mark_in = EDGE_NONE;
         stop_in      = 1'b1;
      end else if (!rising_ff) begin
         if (running_min_in > in_sample_ff) begin
            running_min_in = in_sample_ff;
            valley_pos_in  = position_in;
            against_in     = '0;
            if (edge_mark_ff != EDGE_FALL_LOW) begin
               edge_mark_in = EDGE_FALL_LOW;
               change_in    = sat_inc8(change_ff);
            end
         end else begin
            last_valley_in = running_min_in;
            swing = STEP_W'(running_max_in) - STEP_W'(running_min_in);
            if (edge_mark_ff != EDGE_FALL_TURN) begin
               edge_mark_in = EDGE_FALL_TURN;
               change_in    = sat_inc8(change_ff);
               if (qualifies(swing, change_in, last_peak_in, last_valley_in,
                             swing_threshold_ff, mean_threshold_ff, jitter_limit_ff)) begin
                  step_in   = '0;
                  change_in = '0;
               end
            end
            peak_pos_in    = position_in;
            running_max_in = in_sample_ff;
            against_in     = sat_inc8(against_ff);
            if (trend_confirm_ff < against_in &&
                $signed({2'b00, swing_threshold_ff}) < swing) begin
               rising_in     = 1'b1;
               anchor_pos_in = valley_pos_in;
               last_peak_in  = running_max_in;
               edge_mark_in  = EDGE_NONE;
               against_in    = '0;
            end
         end
      end else begin
         if (running_max_in < in_sample_ff) begin
            running_max_in = in_sample_ff;
            peak_pos_in    = position_in;
            against_in     = '0;
            if (edge_mark_ff != EDGE_RISE_HIGH) begin
               edge_mark_in = EDGE_RISE_HIGH;
               change_in    = sat_inc8(change_ff);
            end
         end else begin
            last_peak_in = running_max_in;
            swing = STEP_W'(running_max_in) - STEP_W'(running_min_in);
            if (edge_mark_ff != EDGE_RISE_TURN) begin
               edge_mark_in = EDGE_RISE_TURN;
               change_in    = sat_inc8(change_ff);
               if (qualifies(swing, change_in, last_peak_in, last_valley_in,
                             swing_threshold_ff, mean_threshold_ff, jitter_limit_ff)) begin
                  if (step_ff < STEP_MAX) begin
                     step_in = step_ff + STEP_W'(1);
                  end
                  change_in = '0;
               end
            end
            valley_pos_in  = position_in;
            running_min_in = in_sample_ff;
            against_in     = sat_inc8(against_ff);
            if (trend_confirm_ff < against_in &&
                $signed({2'b00, swing_threshold_ff}) < swing) begin
               rising_in      = 1'b0;
               anchor_pos_in  = peak_pos_in;
               last_valley_in = running_min_in;
               edge_mark_in   = EDGE_NONE;
               against_in     = '0;
            end
         end
      end
   end

   // handshake control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_sample_ff  <= $signed(req_tdata);
         in_restart_ff <= req_tuser[0];
      end
      if (advance) begin
         out_step_ff  <= step_in;
         out_trend_ff <= rising_in;
         out_stop_ff  <= stop_in;
      end
   end

   // tracking state, advanced once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         anchor_pos_ff  <= '0;
         peak_pos_ff    <= '0;
         valley_pos_ff  <= '0;
         running_max_ff <= '0;
         running_min_ff <= '0;
         last_peak_ff   <= '0;
         last_valley_ff <= '0;
         rising_ff      <= 1'b0;
         edge_mark_ff   <= EDGE_NONE;
         against_ff     <= '0;
         change_ff      <= '0;
         step_ff        <= '0;
      end else if (advance) begin
         position_ff    <= position_in;
         anchor_pos_ff  <= anchor_pos_in;
         peak_pos_ff    <= peak_pos_in;
         valley_pos_ff  <= valley_pos_in;
         running_max_ff <= running_max_in;
         running_min_ff <= running_min_in;
         last_peak_ff   <= last_peak_in;
         last_valley_ff <= last_valley_in;
         rising_ff      <= rising_in;
         edge_mark_ff   <= edge_mark_in;
         against_ff     <= against_in;
         change_ff      <= change_in;
         step_ff        <= step_in;
      end
   end

endmodule

// ===== hw/rtl/pvsd_checker.sv =====
`include "peak_valley_step_detector_defines.svh"

module pvsd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import pvsd_pkg::*;

   // a stalled result item holds
   `PVSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a stop always reports the stopped count
   `PVSD_ASSERT_NOW(a_stop_value, clock, reset, rsp_tvalid && rsp_tuser[1], $signed(rsp_tdata[16:0]) == STEP_STOPPED)

   // nothing comes out straight after reset
   `PVSD_ASSERT_NOW(a_reset_empty, clock, reset, $fell(reset), !rsp_tvalid)

   // an item taken behind a stalled result fills the only spare slot
   `PVSD_ASSERT_NEXT(a_one_spare, clock, reset, rsp_tvalid && !rsp_tready && req_tvalid && req_tready, req_tready == rsp_tready)

endmodule

bind peak_valley_step_detector pvsd_checker u_pvsd_checker (.*);
